// ===== rtl/iale_pkg.sv =====
// ----------------------------------------------------------------------------
// iale_pkg
// Command codes, status codes and fixed field widths of the indexed array
// list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package iale_pkg;

  localparam int CmdW    = 3;
  localparam int StatusW = 3;

  typedef enum logic [CmdW-1:0] {
    CmdInsert    = 3'd0,
    CmdErase     = 3'd1,
    CmdFind      = 3'd2,
    CmdModify    = 3'd3,
    CmdPushBack  = 3'd4,
    CmdPushFront = 3'd5,
    CmdPopBack   = 3'd6,
    CmdPopFront  = 3'd7
  } cmd_e;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StBadPos   = 3'd1;
  localparam logic [StatusW-1:0] StFull     = 3'd2;
  localparam logic [StatusW-1:0] StEmpty    = 3'd3;
  localparam logic [StatusW-1:0] StNotFound = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/iale_ram.sv =====
// ----------------------------------------------------------------------------
// iale_ram
// Element store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iale_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/iale_ctrl.sv =====
// ----------------------------------------------------------------------------
// iale_ctrl
// Command sequencer: checks each command, keeps the count and walks the
// element store with one shared index stepper and comparator for shifts and
// searches.
// ----------------------------------------------------------------------------
`default_nettype none

module iale_ctrl #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [iale_pkg::CmdW-1:0]         command_i,
  input  logic [$clog2(CAPACITY+1)-1:0]     position_i,
  input  logic signed [DATA_WIDTH-1:0]      value_i,
  output logic                              wr_en_o,
  output logic [$clog2(CAPACITY)-1:0]       wr_addr_o,
  output logic [DATA_WIDTH-1:0]             wr_data_o,
  output logic                              rd_en_o,
  output logic [$clog2(CAPACITY)-1:0]       rd_addr_o,
  input  logic [DATA_WIDTH-1:0]             rd_data_i,
  output logic                              res_valid_o,
  input  logic                              res_take_i,
  output logic [iale_pkg::StatusW-1:0]      res_status_o,
  output logic [$clog2(CAPACITY)-1:0]       res_found_o,
  output logic [$clog2(CAPACITY+1)-1:0]     res_count_o
);

  import iale_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SOpen  = 3'd1;
  localparam logic [2:0] SClose = 3'd2;
  localparam logic [2:0] SFind  = 3'd3;
  localparam logic [2:0] SDone  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  pend_q, pend_d;
  logic [IdxW-1:0]       wa_q, wa_d;
  logic [StatusW-1:0]    status_q, status_d;
  logic [IdxW-1:0]       found_q, found_d;

  cmd_e            cmd;
  logic            is_full;
  logic            is_empty;
  logic [CntW-1:0] idx_step;
  logic [CntW-1:0] cmp_lo;
  logic [CntW-1:0] cmp_hi;
  logic            more;
  logic [CntW-1:0] rd_addr_full;

  assign cmd      = cmd_e'(command_i);
  assign is_full  = (count_q == CapCnt);
  assign is_empty = (count_q == '0);

  // shared index stepper and bound comparator
  assign idx_step     = (state_q == SOpen) ? idx_q - 1'b1 : idx_q + 1'b1;
  assign cmp_lo       = (state_q == SOpen) ? pos_q : idx_q;
  assign cmp_hi       = (state_q == SOpen) ? idx_q : count_q;
  assign more         = (cmp_lo < cmp_hi);
  assign rd_addr_full = (state_q == SFind) ? idx_q : idx_step;
  assign rd_addr_o    = rd_addr_full[IdxW-1:0];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    val_d     = val_q;
    pend_d    = 1'b0;
    wa_d      = wa_q;
    status_d  = status_q;
    found_d   = found_q;
    wr_en_o   = 1'b0;
    wr_addr_o = pos_q[IdxW-1:0];
    wr_data_o = val_q;
    rd_en_o   = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          val_d    = value_i;
          pos_d    = position_i;
          found_d  = '0;
          status_d = StOk;
          idx_d    = '0;
          state_d  = SDone;
          unique case (cmd)
            CmdInsert: begin
              if (position_i > count_q) begin
                status_d = StBadPos;
              end else if (is_full) begin
                status_d = StFull;
              end else begin
                idx_d   = count_q;
                count_d = count_q + 1'b1;
                state_d = SOpen;
              end
            end
            CmdErase: begin
              if (is_empty) begin
                status_d = StEmpty;
              end else if (position_i >= count_q) begin
                status_d = StBadPos;
              end else begin
                idx_d   = position_i;
                count_d = count_q - 1'b1;
                state_d = SClose;
              end
            end
            CmdFind: begin
              state_d = SFind;
            end
            CmdModify: begin
              if (is_empty) begin
                status_d = StEmpty;
              end else if (position_i >= count_q) begin
                status_d = StBadPos;
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = position_i[IdxW-1:0];
                wr_data_o = value_i;
              end
            end
            CmdPushBack: begin
              if (is_full) begin
                status_d = StFull;
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = count_q[IdxW-1:0];
                wr_data_o = value_i;
                count_d   = count_q + 1'b1;
              end
            end
            CmdPushFront: begin
              if (is_full) begin
                status_d = StFull;
              end else begin
                pos_d   = '0;
                idx_d   = count_q;
                count_d = count_q + 1'b1;
                state_d = SOpen;
              end
            end
            CmdPopBack: begin
              if (is_empty) begin
                status_d = StEmpty;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            CmdPopFront: begin
              if (is_empty) begin
                status_d = StEmpty;
              end else begin
                count_d = count_q - 1'b1;
                state_d = SClose;
              end
            end
          endcase
        end
      end
      SOpen: begin
        if (pend_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = wa_q;
          wr_data_o = rd_data_i;
        end
        if (more) begin
          rd_en_o = 1'b1;
          pend_d  = 1'b1;
          wa_d    = idx_q[IdxW-1:0];
          idx_d   = idx_step;
        end else if (!pend_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = pos_q[IdxW-1:0];
          wr_data_o = val_q;
          state_d   = SDone;
        end
      end
      SClose: begin
        if (pend_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = wa_q;
          wr_data_o = rd_data_i;
        end
        if (more) begin
          rd_en_o = 1'b1;
          pend_d  = 1'b1;
          wa_d    = idx_q[IdxW-1:0];
          idx_d   = idx_step;
        end else if (!pend_q) begin
          state_d = SDone;
        end
      end
      SFind: begin
        if (pend_q && (rd_data_i == val_q)) begin
          found_d = wa_q;
          state_d = SDone;
        end else if (more) begin
          rd_en_o = 1'b1;
          pend_d  = 1'b1;
          wa_d    = idx_q[IdxW-1:0];
          idx_d   = idx_step;
        end else begin
          status_d = StNotFound;
          state_d  = SDone;
        end
      end
      SDone: begin
        if (res_take_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    wa_q     <= wa_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign in_stall_o   = (state_q != SIdle);
  assign res_valid_o  = (state_q == SDone);
  assign res_status_o = status_q;
  assign res_found_o  = found_q;
  assign res_count_o  = count_q;

endmodule

`default_nettype wire

// ===== rtl/indexed_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_array_list_engine
// Ordered list of up to CAPACITY signed values with insert, erase, find,
// modify, push and pop commands; one result transaction per command.
//
//   channel | signals                                    | dir
//   --------+--------------------------------------------+-----
//   in      | in_valid_i, in_stall_o, command_i,         | in
//           | position_i, value_i                        |
//   out     | out_valid_o, out_stall_i, status_o,        | out
//           | found_index_o, entry_count_o               |
//
// One command at a time. Modify, push back, pop back and rejected commands
// finish without walking the store. Insert and push front shift entries at
// and above position up one and write the value, erase and pop front shift
// later entries down, and find scans from index 0 until it matches: the
// sequencer moves one element per cycle through the single store port pair.
// Reset empties the list at once; no clearing pass.
// A result waits in the output register while the next command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_array_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [iale_pkg::CmdW-1:0]     command_i,
  input  logic [$clog2(CAPACITY+1)-1:0] position_i,
  input  logic signed [DATA_WIDTH-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [iale_pkg::StatusW-1:0]  status_o,
  output logic [$clog2(CAPACITY)-1:0]   found_index_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o
);

  import iale_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);

  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  res_valid;
  logic                  res_take;
  logic [StatusW-1:0]    res_status;
  logic [IdxW-1:0]       res_found;
  logic [CntW-1:0]       res_count;

  logic                  out_valid_q;
  logic [StatusW-1:0]    status_q;
  logic [IdxW-1:0]       found_q;
  logic [CntW-1:0]       count_q;

  iale_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_status_o (res_status),
    .res_found_o  (res_found),
    .res_count_o  (res_count)
  );

  iale_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      status_q <= res_status;
      found_q  <= res_found;
      count_q  <= res_count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign entry_count_o = count_q;

endmodule

`default_nettype wire
